[hdl/sfla_pkg.sv]
// Shared types, codes and size-class helpers for the segregated free-list allocator.
package sfla_pkg;

    localparam logic [1:0] ACT_ALLOCATE   = 2'd0;
    localparam logic [1:0] ACT_REALLOCATE = 2'd1;
    localparam logic [1:0] ACT_FREE       = 2'd2;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

    localparam logic [1:0] CLS_ONE_KIB = 2'd0;
    localparam logic [1:0] CLS_150_KIB = 2'd1;
    localparam logic [1:0] CLS_ONE_MIB = 2'd2;
    localparam logic [1:0] CLS_LARGE   = 2'd3;

    localparam logic [24:0] EMPTY_LINK   = 25'h1FF_FFFF;
    localparam logic [24:0] SIZE_ONE_KIB = 25'd1024;
    localparam logic [24:0] SIZE_150_KIB = 25'd153600;
    localparam logic [24:0] SIZE_ONE_MIB = 25'd1048576;
    localparam logic [24:0] LIMIT_RESET  = 25'h100_0000;

    typedef struct packed {
        logic [1:0]  action;
        logic [23:0] request_bytes;
        logic [23:0] data_address;
    } alloc_request_t;

    typedef struct packed {
        logic        status;
        logic [23:0] result_address;
        logic        copy_needed;
        logic [23:0] copy_from;
        logic [23:0] copy_length;
    } alloc_result_t;

    // One block header as held in the header memory.
    typedef struct packed {
        logic [24:0] allocated_size;
        logic [23:0] requested_size;
        logic [24:0] next_link;
    } header_entry_t;

    // Class picked by an allocation from its size including the header.
    function automatic logic [1:0] alloc_class(input logic [24:0] need);
        logic [1:0] cls;
        if (need < SIZE_ONE_KIB) cls = CLS_ONE_KIB;
        else if (need < SIZE_150_KIB) cls = CLS_150_KIB;
        else if (need < SIZE_ONE_MIB) cls = CLS_ONE_MIB;
        else cls = CLS_LARGE;
        return cls;
    endfunction

    // Class a freed block returns to, chosen by its allocated size.
    function automatic logic [1:0] free_class(input logic [24:0] size);
        logic [1:0] cls;
        if (size <= SIZE_ONE_KIB) cls = CLS_ONE_KIB;
        else if (size <= SIZE_150_KIB) cls = CLS_150_KIB;
        else if (size <= SIZE_ONE_MIB) cls = CLS_ONE_MIB;
        else cls = CLS_LARGE;
        return cls;
    endfunction

    // Block size carved for a class; the large class carves exactly what is needed.
    function automatic logic [24:0] class_size(input logic [1:0] cls, input logic [24:0] need);
        logic [24:0] size;
        case (cls)
            CLS_ONE_KIB: size = SIZE_ONE_KIB;
            CLS_150_KIB: size = SIZE_150_KIB;
            CLS_ONE_MIB: size = SIZE_ONE_MIB;
            default:     size = need;
        endcase
        return size;
    endfunction

endpackage

[hdl/segregated_free_list_allocator.sv]
// Segregated free-list allocator: sequencer around a single-port header memory.
// A free reads the old header, then pushes the block onto a list. An allocation pops a
// listed block after reading its header, or carves at the bump pointer. A reallocation
// reads the old header and updates it in place, or allocates anew, rereads and frees
// the old block. A request is taken only when idle; the memory does one access per cycle.
// Reset empties the lists, clears the bump pointer and sets a 16 MiB heap limit at once.
module segregated_free_list_allocator
    import sfla_pkg::*;
#(
    parameter int HEAP_ADDR_BITS = 24,
    parameter int HEADER_BYTES   = 24
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           request_valid,
    output logic           request_stall,
    input  alloc_request_t request,
    output logic           result_valid,
    input  logic           result_stall,
    output alloc_result_t  result,
    input  logic           heap_limit_write_enable,
    input  logic [24:0]    heap_limit_write_data
);

    localparam int AW = HEAP_ADDR_BITS;
    // Width that holds both a 25-bit link and a memory index.
    localparam int CW = (AW > 25) ? AW : 25;
    localparam logic [24:0]   HDR_25 = 25'(HEADER_BYTES);
    localparam logic [AW-1:0] HDR_AW = AW'(HEADER_BYTES);
    // Heap depth as a cap on the limit; at 25 or more address bits no limit reaches it.
    localparam logic [25:0]   DEPTH_CAP = (AW >= 25) ? 26'h3FF_FFFF : 26'(64'd1 << AW);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_AEVAL = 3'd3;
    localparam logic [2:0] S_AOK   = 3'd4;
    localparam logic [2:0] S_RCHK  = 3'd5;
    localparam logic [2:0] S_REL   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]    state_reg,     state_next;
    logic [1:0]    act_reg,       act_next;
    logic [23:0]   bytes_reg,     bytes_next;
    logic [23:0]   data_reg,      data_next;
    logic [24:0]   need_reg,      need_next;
    logic [1:0]    cls_reg,       cls_next;
    logic          move_reg,      move_next;
    logic [AW-1:0] old_slot_reg,  old_slot_next;
    logic [24:0]   new_blk_reg,   new_blk_next;
    logic [24:0]   bump_used_reg, bump_used_next;
    alloc_result_t res_reg,       res_next;
    alloc_result_t out_reg,       out_next;
    logic          out_valid_reg, out_valid_next;
    logic [24:0]   heap_limit_reg;
    logic [24:0]   head_reg [4];
    header_entry_t rd_data_reg;

    // The memory holds one header per block offset. Reads and writes are issued only
    // by the sequencer, one access per cycle, and each read is consumed in the state
    // right after it, so a read never overlaps a write to the same entry.
    header_entry_t header_mem [2**HEAP_ADDR_BITS];

    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    header_entry_t mem_wr_data;

    logic [1:0]    head_sel;
    logic          head_we;
    logic [24:0]   head_wdata;
    logic [24:0]   head_cur;

    logic [CW-1:0] head_ext;
    logic [CW-1:0] bump_ext;
    logic [CW-1:0] old_ext;
    logic [AW-1:0] head_slot;
    logic [AW-1:0] bump_slot;
    logic [24:0]   old_blk;
    logic [25:0]   limit_cap;
    logic [24:0]   carve_size;
    logic [25:0]   carve_end;
    logic          carve_fit;
    logic          request_accept;
    logic [24:0]   request_need;

    assign request_stall  = (state_reg != S_IDLE);
    assign request_accept = request_valid && !request_stall;
    assign request_need   = {1'b0, request.request_bytes} + HDR_25;
    assign result_valid   = out_valid_reg;
    assign result         = out_reg;

    // A link or the bump pointer addresses the memory through its low address bits.
    assign head_cur  = head_reg[head_sel];
    assign head_ext  = CW'(head_cur);
    assign bump_ext  = CW'(bump_used_reg);
    assign old_ext   = CW'(old_slot_reg);
    assign head_slot = head_ext[AW-1:0];
    assign bump_slot = bump_ext[AW-1:0];
    assign old_blk   = old_ext[24:0];

    // Carving from the bump pointer must stay within the limit, capped at the heap size.
    assign limit_cap  = ({1'b0, heap_limit_reg} > DEPTH_CAP) ? DEPTH_CAP
                                                             : {1'b0, heap_limit_reg};
    assign carve_size = class_size(cls_reg, need_reg);
    assign carve_end  = {1'b0, bump_used_reg} + {1'b0, carve_size};
    assign carve_fit  = (carve_end <= limit_cap);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        bytes_next     = bytes_reg;
        data_next      = data_reg;
        need_next      = need_reg;
        cls_next       = cls_reg;
        move_next      = move_reg;
        old_slot_next  = old_slot_reg;
        new_blk_next   = new_blk_reg;
        bump_used_next = bump_used_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = '0;
        head_sel       = cls_reg;
        head_we        = 1'b0;
        head_wdata     = EMPTY_LINK;

        // The result register empties when the consumer takes it.
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // Latch the request and its class; the header offset of the existing
                // block wraps within the heap address space.
                if (request_accept)
                begin
                    act_next      = request.action;
                    bytes_next    = request.request_bytes;
                    data_next     = request.data_address;
                    need_next     = request_need;
                    cls_next      = alloc_class(request_need);
                    old_slot_next = AW'(request.data_address) - HDR_AW;
                    move_next     = 1'b0;
                    res_next      = '0;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                case (act_reg)
                    ACT_ALLOCATE:
                    begin
                        state_next = S_ALLOC;
                    end
                    ACT_REALLOCATE:
                    begin
                        // Reallocating no block is a plain allocation.
                        if (data_reg == 24'd0)
                        begin
                            state_next = S_ALLOC;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = old_slot_reg;
                            state_next  = S_RCHK;
                        end
                    end
                    ACT_FREE:
                    begin
                        // Freeing no block does nothing.
                        if (data_reg == 24'd0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = old_slot_reg;
                            state_next  = S_REL;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ALLOC:
            begin
                // A non-empty list is read first; the large class must also check
                // the head block's size before it may be reused.
                if (head_cur != EMPTY_LINK)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = head_slot;
                    state_next  = S_AEVAL;
                end
                else if (carve_fit)
                begin
                    mem_wr_en      = 1'b1;
                    mem_wr_addr    = bump_slot;
                    mem_wr_data    = '{carve_size, bytes_reg, EMPTY_LINK};
                    new_blk_next   = bump_used_reg;
                    bump_used_next = carve_end[24:0];
                    state_next     = S_AOK;
                end
                else
                begin
                    res_next.status = STATUS_EXHAUSTED;
                    state_next      = S_DONE;
                end
            end
            S_AEVAL:
            begin
                if (cls_reg != CLS_LARGE || rd_data_reg.allocated_size > need_reg)
                begin
                    // Pop the head block and stamp the new requested size on it.
                    mem_wr_en    = 1'b1;
                    mem_wr_addr  = head_slot;
                    mem_wr_data  = '{rd_data_reg.allocated_size, bytes_reg, EMPTY_LINK};
                    head_we      = 1'b1;
                    head_wdata   = rd_data_reg.next_link;
                    new_blk_next = head_cur;
                    state_next   = S_AOK;
                end
                else if (carve_fit)
                begin
                    mem_wr_en      = 1'b1;
                    mem_wr_addr    = bump_slot;
                    mem_wr_data    = '{carve_size, bytes_reg, EMPTY_LINK};
                    new_blk_next   = bump_used_reg;
                    bump_used_next = carve_end[24:0];
                    state_next     = S_AOK;
                end
                else
                begin
                    res_next.status = STATUS_EXHAUSTED;
                    state_next      = S_DONE;
                end
            end
            S_AOK:
            begin
                res_next.result_address = new_blk_reg[23:0] + HDR_25[23:0];
                // After a move the old header is read again, since the new block
                // has been written by now; it gives both copy length and free size.
                if (move_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = old_slot_reg;
                    state_next  = S_REL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RCHK:
            begin
                if (rd_data_reg.allocated_size > need_reg)
                begin
                    // The block is big enough: keep it and update its requested size.
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = old_slot_reg;
                    mem_wr_data = '{rd_data_reg.allocated_size, bytes_reg,
                                    rd_data_reg.next_link};
                    res_next.result_address = data_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    move_next  = 1'b1;
                    state_next = S_ALLOC;
                end
            end
            S_REL:
            begin
                // Push the old block onto the list of its size class.
                head_sel    = free_class(rd_data_reg.allocated_size);
                mem_wr_en   = 1'b1;
                mem_wr_addr = old_slot_reg;
                mem_wr_data = '{rd_data_reg.allocated_size, rd_data_reg.requested_size,
                                head_cur};
                head_we     = 1'b1;
                head_wdata  = old_blk;
                if (move_reg)
                begin
                    res_next.copy_needed = 1'b1;
                    res_next.copy_from   = data_reg;
                    res_next.copy_length = rd_data_reg.requested_size;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Wait here only while the previous result is still held by the consumer.
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            bump_used_reg  <= 25'd0;
            heap_limit_reg <= LIMIT_RESET;
            move_reg       <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                head_reg[i] <= EMPTY_LINK;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bump_used_reg <= bump_used_next;
            move_reg      <= move_next;
            if (heap_limit_write_enable)
            begin
                heap_limit_reg <= heap_limit_write_data;
            end
            if (head_we)
            begin
                head_reg[head_sel] <= head_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        bytes_reg    <= bytes_next;
        data_reg     <= data_next;
        need_reg     <= need_next;
        cls_reg      <= cls_next;
        old_slot_reg <= old_slot_next;
        new_blk_reg  <= new_blk_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            header_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            rd_data_reg <= header_mem[mem_rd_addr];
        end
    end

    // The single memory port never serves a read and a write in the same cycle.
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("header memory read and write issued together");

    // List-pop evaluation always consumes the read issued in the cycle before.
    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AEVAL) |-> ($past(state_reg) == S_ALLOC && $past(mem_rd_en)))
        else $error("pop evaluated without a preceding header read");

    // An exhausted heap returns no address and never reports a copy.
    a_exhausted_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == STATUS_EXHAUSTED)
            |-> (result.result_address == 24'd0 && !result.copy_needed))
        else $error("exhausted result carries an address or a copy");

    // A new result is only presented after the sequencer finished a request.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == S_DONE))
        else $error("result presented outside the completion step");

endmodule

[bench/segregated_free_list_allocator_tb.sv]
// Self-checking testbench for the segregated free-list allocator.
`timescale 1ns / 100ps

module segregated_free_list_allocator_tb
    import sfla_pkg::*;
();

    // The block is built with its default geometry: 24 address bits and a 24-byte header.
    localparam int HDR_LEN = 24;

    // Action code 3 is not defined by the package; the block must ignore it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Smallest request that no longer fits each class once the header is added.
    localparam logic [23:0] KIB_FIT  = 24'(SIZE_ONE_KIB - HDR_LEN);
    localparam logic [23:0] K150_FIT = 24'(SIZE_150_KIB - HDR_LEN);
    localparam logic [23:0] MIB_FIT  = 24'(SIZE_ONE_MIB - HDR_LEN);
    localparam logic [24:0] LIMIT_MAX = 25'h1FF_FFFF;

    // Quiet cycles waited after the last result, enough to leave the block idle.
    localparam int DRAIN_CYCLES = 12;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           request_valid = 1'b0;
    logic           request_stall;
    alloc_request_t request = '0;
    logic           result_valid;
    logic           result_stall = 1'b0;
    alloc_result_t  result;
    logic           heap_limit_write_enable = 1'b0;
    logic [24:0]    heap_limit_write_data = '0;

    // Idle controls for the two sides, changed between phases of the run.
    bit       sender_gaps_on = 1'b1;
    bit       sink_stalls_on = 1'b1;
    bit [2:0] stall_left = '0;

    // Results the allocator still owes, oldest first, and the failure count.
    alloc_result_t outstanding_results[$];
    int            mismatch_count = 0;

    // Data offsets of the blocks that are currently allocated, as the prediction sees them.
    logic [23:0] live_data[$];

    // Predicted allocator state: register, bump pointer, list heads and block headers.
    // The header stores are sparse since only handed-out block offsets are ever touched.
    logic [24:0] heap_limit_model;
    logic [24:0] bump_used;
    logic [24:0] list_head [4];
    logic [24:0] hdr_alloc_size [int unsigned];
    logic [23:0] hdr_req_size [int unsigned];
    logic [24:0] hdr_next_link [int unsigned];

    // Blocks handed out by the directed tests and reused by later ones.
    logic [23:0] small_block;
    logic [23:0] edge_block;
    logic [23:0] mib_exact_block;

    segregated_free_list_allocator u_dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .request_valid           (request_valid),
        .request_stall           (request_stall),
        .request                 (request),
        .result_valid            (result_valid),
        .result_stall            (result_stall),
        .result                  (result),
        .heap_limit_write_enable (heap_limit_write_enable),
        .heap_limit_write_data   (heap_limit_write_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator prediction
    // ------------------------------------------------------------------

    // Carves a fresh block from the bump pointer. Limits above the 16 MiB heap
    // behave as the heap size. A failed carve leaves every piece of state alone.
    function automatic bit heap_carve(input logic [24:0] size, input logic [23:0] req_bytes,
                                      output logic [23:0] blk);
        logic [25:0] cap;
        cap = (heap_limit_model > LIMIT_RESET) ? {1'b0, LIMIT_RESET} : {1'b0, heap_limit_model};
        blk = '0;
        if ({1'b0, bump_used} + {1'b0, size} > cap)
            return 1'b0;
        blk = bump_used[23:0];
        bump_used = bump_used + size;
        hdr_alloc_size[blk] = size;
        hdr_req_size[blk] = req_bytes;
        hdr_next_link[blk] = EMPTY_LINK;
        return 1'b1;
    endfunction

    // Takes the head block of one free list; its link is cleared and its requested size updated.
    function automatic logic [23:0] list_pop(input logic [1:0] cls, input logic [23:0] req_bytes);
        logic [23:0] blk;
        blk = list_head[cls][23:0];
        list_head[cls] = hdr_next_link[blk];
        hdr_next_link[blk] = EMPTY_LINK;
        hdr_req_size[blk] = req_bytes;
        return blk;
    endfunction

    // The three fixed classes reuse any listed block and carve only when the list is empty.
    function automatic bit class_take(input logic [1:0] cls, input logic [24:0] size,
                                      input logic [23:0] req_bytes, output logic [23:0] blk);
        if (list_head[cls] != EMPTY_LINK)
        begin
            blk = list_pop(cls, req_bytes);
            return 1'b1;
        end
        return heap_carve(size, req_bytes, blk);
    endfunction

    function automatic bit heap_allocate(input logic [23:0] req_bytes, output logic [23:0] data);
        logic [24:0] need;
        logic [23:0] blk;
        bit          ok;
        need = 25'({1'b0, req_bytes} + HDR_LEN);
        blk = '0;
        if (need < SIZE_ONE_KIB)
            ok = class_take(CLS_ONE_KIB, SIZE_ONE_KIB, req_bytes, blk);
        else if (need < SIZE_150_KIB)
            ok = class_take(CLS_150_KIB, SIZE_150_KIB, req_bytes, blk);
        else if (need < SIZE_ONE_MIB)
            ok = class_take(CLS_ONE_MIB, SIZE_ONE_MIB, req_bytes, blk);
        else if (list_head[CLS_LARGE] != EMPTY_LINK &&
                 hdr_alloc_size[list_head[CLS_LARGE][23:0]] > need)
        begin
            // A large block is reused only when it is strictly bigger than the need.
            blk = list_pop(CLS_LARGE, req_bytes);
            ok = 1'b1;
        end
        else
            ok = heap_carve(need, req_bytes, blk);
        data = ok ? 24'(blk + HDR_LEN) : '0;
        return ok;
    endfunction

    // Pushes a block onto the list picked by its allocated size; a null offset does nothing.
    function automatic void block_free_push(input logic [23:0] data);
        logic [23:0] blk;
        logic [24:0] size;
        logic [1:0]  cls;
        if (data == '0)
            return;
        blk = 24'(data - HDR_LEN);
        size = hdr_alloc_size[blk];
        if (size <= SIZE_ONE_KIB)
            cls = CLS_ONE_KIB;
        else if (size <= SIZE_150_KIB)
            cls = CLS_150_KIB;
        else if (size <= SIZE_ONE_MIB)
            cls = CLS_ONE_MIB;
        else
            cls = CLS_LARGE;
        hdr_next_link[blk] = list_head[cls];
        list_head[cls] = {1'b0, blk};
    endfunction

    function automatic alloc_result_t predict_request(input alloc_request_t req);
        alloc_result_t res;
        logic [23:0]   blk;
        logic [24:0]   need;
        logic [23:0]   new_data;
        res = '0;
        new_data = '0;
        need = 25'({1'b0, req.request_bytes} + HDR_LEN);
        case (req.action)
            ACT_ALLOCATE:
            begin
                res.status = heap_allocate(req.request_bytes, new_data) ? STATUS_OK
                                                                         : STATUS_EXHAUSTED;
                res.result_address = new_data;
            end
            ACT_REALLOCATE:
            begin
                if (req.data_address == '0)
                begin
                    res.status = heap_allocate(req.request_bytes, new_data) ? STATUS_OK
                                                                             : STATUS_EXHAUSTED;
                    res.result_address = new_data;
                end
                else
                begin
                    blk = 24'(req.data_address - HDR_LEN);
                    if (hdr_alloc_size[blk] > need)
                    begin
                        hdr_req_size[blk] = req.request_bytes;
                        res.result_address = req.data_address;
                    end
                    else if (heap_allocate(req.request_bytes, new_data))
                    begin
                        // The old length is read only after the new block is taken.
                        res.result_address = new_data;
                        res.copy_needed = 1'b1;
                        res.copy_from = req.data_address;
                        res.copy_length = hdr_req_size[blk];
                        block_free_push(req.data_address);
                    end
                    else
                        res.status = STATUS_EXHAUSTED;
                end
            end
            ACT_FREE:
                block_free_push(req.data_address);
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic int live_index(input logic [23:0] data);
        foreach (live_data[i])
            if (live_data[i] == data)
                return i;
        return -1;
    endfunction

    // Request sizes weighted toward the small class, with every class edge now and then.
    function automatic logic [23:0] pick_request_bytes();
        int unsigned roll;
        logic [23:0] bytes;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            bytes = 24'($urandom_range(0, KIB_FIT - 1));
        else if (roll < 76)
            bytes = 24'($urandom_range(KIB_FIT, K150_FIT - 1));
        else if (roll < 83)
            bytes = 24'($urandom_range(K150_FIT, MIB_FIT - 1));
        else if (roll < 88)
            bytes = 24'($urandom_range(MIB_FIT, 3000000));
        else if (roll < 90)
            bytes = 24'($urandom);
        else
            case (roll % 6)
                0:       bytes = KIB_FIT - 24'd1;
                1:       bytes = KIB_FIT;
                2:       bytes = K150_FIT - 24'd1;
                3:       bytes = K150_FIT;
                4:       bytes = MIB_FIT - 24'd1;
                default: bytes = MIB_FIT;
            endcase
        return bytes;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Sends one request. The expected result is worked out and queued before the
    // request goes out, and the set of live blocks follows the prediction, so later
    // requests free and reallocate only offsets that the allocator really handed out.
    task automatic send_request(input logic [1:0] act, input logic [23:0] bytes,
                                input logic [23:0] addr, output alloc_result_t predicted);
        alloc_request_t item;
        int             idx;
        item.action = act;
        item.request_bytes = bytes;
        item.data_address = addr;
        if (sender_gaps_on && $urandom_range(0, 3) == 0)
        begin
            request_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        predicted = predict_request(item);
        outstanding_results.push_back(predicted);
        if (act == ACT_FREE)
        begin
            idx = live_index(addr);
            if (idx >= 0)
                live_data.delete(idx);
        end
        else if (act == ACT_REALLOCATE && predicted.copy_needed)
        begin
            idx = live_index(addr);
            if (idx >= 0)
                live_data[idx] = predicted.result_address;
        end
        else if ((act == ACT_ALLOCATE || (act == ACT_REALLOCATE && addr == '0)) &&
                 predicted.status == STATUS_OK)
            live_data.push_back(predicted.result_address);
        request <= item;
        request_valid <= 1'b1;
        @(posedge clk);
        while (request_stall)
            @(posedge clk);
    endtask

    // Stops sending and waits until every owed result has come and the block is quiet.
    task automatic settle_block();
        if (request_valid)
        begin
            request_valid <= 1'b0;
            @(posedge clk);
        end
        while (outstanding_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The heap limit is only ever written while the block has nothing in work.
    task automatic set_heap_limit(input logic [24:0] value);
        settle_block();
        heap_limit_write_enable <= 1'b1;
        heap_limit_write_data <= value;
        @(posedge clk);
        heap_limit_write_enable <= 1'b0;
        heap_limit_model = value;
        @(posedge clk);
    endtask

    // The receiver stalls in random bursts while its stalls are enabled.
    always @(posedge clk)
    begin
        if (!sink_stalls_on)
            result_stall <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 3'd1;
            result_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= 3'($urandom_range(0, 6));
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Every accepted result is matched against the oldest owed one.
    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (outstanding_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with none owed: status %0d addr %h copy %0d",
                             $time, result.status, result.result_address, result.copy_needed,
                             " from %h len %h", result.copy_from, result.copy_length);
            end
            else
            begin
                want = outstanding_results.pop_front();
                if (result.status !== want.status ||
                    result.result_address !== want.result_address ||
                    result.copy_needed !== want.copy_needed ||
                    result.copy_from !== want.copy_from ||
                    result.copy_length !== want.copy_length)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch exp/got status %0d/%0d addr %h/%h",
                                 $time, want.status, result.status,
                                 want.result_address, result.result_address,
                                 " copy %0d/%0d from %h/%h len %h/%h",
                                 want.copy_needed, result.copy_needed,
                                 want.copy_from, result.copy_from,
                                 want.copy_length, result.copy_length);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Allocations on both sides of the 1 KiB edge and just above the other two, then one that can never fit.
    task automatic test_size_classes();
        alloc_result_t r;
        send_request(ACT_ALLOCATE, 24'd0, 24'hFF_FFFF, r);
        small_block = r.result_address;
        send_request(ACT_ALLOCATE, KIB_FIT - 24'd1, 24'd0, r);
        edge_block = r.result_address;
        send_request(ACT_ALLOCATE, KIB_FIT, 24'd0, r);
        send_request(ACT_ALLOCATE, K150_FIT, 24'd0, r);
        send_request(ACT_ALLOCATE, MIB_FIT, 24'd0, r);
        mib_exact_block = r.result_address;
        send_request(ACT_ALLOCATE, 24'hFF_FFFF, 24'd0, r);
    endtask

    // Freed blocks come back LIFO. A large block of exactly one MiB returns to the
    // one MiB list, and the large list gives its head back only to a smaller need.
    task automatic test_list_reuse();
        alloc_result_t r;
        logic [23:0]   big_block;
        send_request(ACT_FREE, 24'd0, small_block, r);
        send_request(ACT_ALLOCATE, 24'd5, 24'd0, r);
        small_block = r.result_address;
        send_request(ACT_FREE, 24'd0, mib_exact_block, r);
        send_request(ACT_ALLOCATE, 24'd500000, 24'd0, r);
        send_request(ACT_ALLOCATE, 24'd2000000, 24'd0, r);
        big_block = r.result_address;
        send_request(ACT_FREE, 24'd0, big_block, r);
        send_request(ACT_ALLOCATE, 24'd2000000, 24'd0, r);
        send_request(ACT_ALLOCATE, 24'd1500000, 24'd0, r);
    endtask

    // Shrinking stays in place; growing to exactly the block size moves the block;
    // a null offset behaves as a plain allocation.
    task automatic test_reallocate();
        alloc_result_t r;
        send_request(ACT_REALLOCATE, 24'd10, edge_block, r);
        send_request(ACT_REALLOCATE, KIB_FIT, edge_block, r);
        edge_block = r.result_address;
        send_request(ACT_REALLOCATE, 24'd100, 24'd0, r);
    endtask

    task automatic test_null_and_unknown();
        alloc_result_t r;
        send_request(ACT_FREE, 24'hFF_FFFF, 24'd0, r);
        send_request(ACT_UNUSED, 24'hFF_FFFF, 24'hFF_FFFF, r);
    endtask

    // With a zero limit only list reuse succeeds. A failed move leaves the old
    // block allocated, which the free afterwards relies on.
    task automatic test_exhausted_heap();
        alloc_result_t r;
        set_heap_limit(25'd0);
        send_request(ACT_ALLOCATE, 24'd10, 24'd0, r);
        send_request(ACT_ALLOCATE, 24'd10, 24'd0, r);
        send_request(ACT_REALLOCATE, 24'd400000, small_block, r);
        send_request(ACT_FREE, 24'd0, small_block, r);
        set_heap_limit(LIMIT_MAX);
        send_request(ACT_ALLOCATE, MIB_FIT, 24'd0, r);
    endtask

    // Mostly well-formed traffic on live blocks, with some ignored requests mixed in.
    // Those ignored requests do not count toward the number asked for.
    task automatic run_random_mix(input int count);
        alloc_result_t r;
        int            sent;
        int unsigned   roll;
        logic [23:0]   target;
        sent = 0;
        while (sent < count)
        begin
            roll = $urandom_range(0, 99);
            if (live_data.size() == 0 && roll >= 45)
                roll = 20;
            else if (live_data.size() > 400 && roll >= 5 && roll < 45)
                roll = 80;
            if (roll < 3)
                send_request(ACT_UNUSED, 24'($urandom), 24'($urandom), r);
            else if (roll < 5)
                send_request(ACT_FREE, 24'($urandom), 24'd0, r);
            else
            begin
                sent++;
                if (roll < 45)
                    send_request(ACT_ALLOCATE, pick_request_bytes(), 24'($urandom), r);
                else if (roll < 65)
                begin
                    target = ($urandom_range(0, 9) == 0) ? 24'd0
                             : live_data[$urandom_range(0, live_data.size() - 1)];
                    send_request(ACT_REALLOCATE, pick_request_bytes(), target, r);
                end
                else
                begin
                    target = live_data[$urandom_range(0, live_data.size() - 1)];
                    send_request(ACT_FREE, 24'($urandom), target, r);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        heap_limit_model = LIMIT_RESET;
        bump_used = '0;
        foreach (list_head[i])
            list_head[i] = EMPTY_LINK;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_size_classes();
        test_list_reuse();
        test_reallocate();
        test_null_and_unknown();
        test_exhausted_heap();

        // The random phases step through several limits. Each write waits for the
        // block to drain, so the sender is held off until every result has come.
        set_heap_limit(25'h0A0_0000);
        run_random_mix(500);

        sink_stalls_on = 1'b0;
        set_heap_limit(LIMIT_MAX);
        run_random_mix(450);

        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b1;
        set_heap_limit(25'($urandom_range(LIMIT_RESET, bump_used)));
        run_random_mix(450);

        // The last part runs at full rate with no idling on either side.
        sink_stalls_on = 1'b0;
        set_heap_limit(LIMIT_RESET);
        run_random_mix(400);

        settle_block();
        if (mismatch_count == 0 && outstanding_results.size() == 0)
            $display("[segregated_free_list_allocator] OK");
        else
            $display("[segregated_free_list_allocator] ERROR");
        $finish;
    end

    // This bound only catches a hang of the run.
    initial
    begin : watchdog
        #10_000_000;
        $display("[segregated_free_list_allocator] ERROR");
        $finish;
    end

endmodule
